@@ hdl/dwsp_pkg.sv @@
// Shared constants and a saturation function for the two-wheel speed controller.
`default_nettype none
package dwsp_pkg;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KP = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KI = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACCEL = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DPT_L = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DPT_R = 3'd6;
  localparam int InW = 128;
  localparam int OutW = 64;
  localparam logic signed [47:0] I48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] I48Min = 48'sh8000_0000_0000;

  // saturate a wide signed value into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    logic signed [31:0] r;
    if (v > 96'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -96'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/dwsp_mul.sv @@
// Shift-and-add signed multiplier and restoring divider, one bit per cycle.
`default_nettype none
module dwsp_mul (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                div,
  input  wire logic signed [63:0]  a,
  input  wire logic signed [63:0]  b,
  output logic                     done,
  output logic signed [95:0]       res
);
  import dwsp_pkg::*;
  logic busy;
  logic [6:0] cnt;
  logic [95:0] acc;
  logic [63:0] ua, ub;
  logic neg;
  logic [96:0] trial;

  assign trial = {acc[95:0], ua[63]} - {33'd0, ub};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      ua <= a[63] ? -a : a;
      ub <= b[63] ? -b : b;
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      if (div) begin
        if (!trial[96]) begin
          acc <= trial[95:0];
          ua <= {ua[62:0], 1'b1};
        end else begin
          acc <= {acc[94:0], ua[63]};
          ua <= {ua[62:0], 1'b0};
        end
      end else begin
        acc <= {acc[94:0], 1'b0} + (ua[63] ? {32'd0, ub} : 96'd0);
        ua <= {ua[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    logic [95:0] m;
    m = div ? {32'd0, ua} : acc;
    if (div && !trial[96] && cnt == 7'd0) m = {32'd0, ua};
    res = neg ? -$signed(m) : $signed(m);
  end

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("start lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 7'd0)
    else $error("bad count");
`endif
endmodule
`default_nettype wire

@@ hdl/dual_wheel_speed_pid_ramp_top.sv @@
// Top level of the two-wheel ramped PID speed controller.
// Datapath: one shared bit-serial unit for every multiply or divide. A set beat with
// a ramp runs 3 operations; a sample with an update runs 12 to 14 operations.
// One beat at a time: s_tready is high only in the idle state, entered as the result beat is registered.
// Reset (rst, synchronous) restores register defaults, returns to idle and clears the controller history.
`default_nettype none
module dual_wheel_speed_pid_ramp_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic                         s_tuser,  // req_type
  // time_ms, count_left, count_right, target_left, target_right
  input  wire logic [159:0]                 s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic                              m_tuser,  // updated
  output logic [63:0]                       m_tdata,  // pwm_left, pwm_right
  input  wire logic                         cfg_we,
  input  wire logic [dwsp_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [dwsp_pkg::CfgDataW-1:0] cfg_data
);
  import dwsp_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_R0, S_R1, S_R2, S_R3, S_P0, S_P1, S_P2, S_P3, S_P4,
    S_P5, S_P6, S_P7, S_P8, S_NEXT, S_OUT
  } st_t;
  st_t st;

  logic [15:0] period;
  logic [23:0] kp, kd, ki;
  logic [31:0] accel, dpt_l, dpt_r;
  logic [31:0] last_t, rs_time, rdur;
  logic [31:0] lastc [2];
  logic signed [31:0] meas [2], tgt [2], rate [2], perr [2], drv [2];
  logic signed [47:0] esum [2];
  logic [31:0] tm;
  logic [31:0] cnt [2];
  logic req;
  logic w;
  logic lead;
  logic signed [31:0] dl, dot, e, ramped;
  logic signed [63:0] hi, lo;
  logic signed [95:0] acc;
  logic upd;
  logic mstart, mdiv, mdone;
  logic signed [63:0] ma, mb;
  logic signed [95:0] mres;

  dwsp_mul u_mul (.clk(clk), .rst(rst), .start(mstart), .div(mdiv), .a(ma), .b(mb),
    .done(mdone), .res(mres));

  assign s_tready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    logic signed [47:0] ns;
    logic [31:0] el;
    mstart <= 1'b0;
    if (rst) begin
      st <= S_IDLE;
      m_tvalid <= 1'b0;
      period <= 16'd10; kp <= 24'd503316; kd <= 24'd134218; ki <= 24'd16777;
      accel <= 32'd26214; dpt_l <= 32'd65536; dpt_r <= 32'd65536;
      last_t <= '0; rs_time <= '0; rdur <= '0;
      for (int i = 0; i < 2; i++) begin
        lastc[i] <= '0; meas[i] <= '0; tgt[i] <= '0; rate[i] <= '0;
        perr[i] <= '0; drv[i] <= '0; esum[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PERIOD: period <= cfg_data[15:0];
          REG_KP: kp <= cfg_data[23:0];
          REG_KD: kd <= cfg_data[23:0];
          REG_KI: ki <= cfg_data[23:0];
          REG_ACCEL: accel <= cfg_data;
          REG_DPT_L: dpt_l <= cfg_data;
          REG_DPT_R: dpt_r <= cfg_data;
          default: ;
        endcase
      end
      case (st)
        S_IDLE: if (s_tvalid) begin
          req <= s_tuser; tm <= s_tdata[31:0];
          cnt[0] <= s_tdata[63:32]; cnt[1] <= s_tdata[95:64];
          if (!s_tuser) begin
            tgt[0] <= s_tdata[127:96]; tgt[1] <= s_tdata[159:128];
          end
          st <= S_DEC;
        end
        S_DEC: begin
          upd <= 1'b0;
          if (!req) begin
            lead <= (tgt[0] < tgt[1]);
            if (tgt[0] < tgt[1]) begin
              dl <= sat32(96'(tgt[1]) - 96'(meas[1]));
              dot <= sat32(96'(tgt[0]) - 96'(meas[0]));
            end else begin
              dl <= sat32(96'(tgt[0]) - 96'(meas[0]));
              dot <= sat32(96'(tgt[1]) - 96'(meas[1]));
            end
            rs_time <= tm;
            st <= S_R0;
          end else if (tm - last_t > {16'd0, period}) begin
            upd <= 1'b1; w <= 1'b0; last_t <= tm; st <= S_P0;
          end else st <= S_OUT;
        end
        S_R0: begin
          if (dl <= 0 || accel == 0) begin
            rdur <= '0; rate[0] <= '0; rate[1] <= '0; st <= S_OUT;
          end else begin
            ma <= 64'(dl) + 64'(accel) - 64'sd1; mb <= 64'(accel); mdiv <= 1'b1;
            mstart <= 1'b1; st <= S_R1;
          end
        end
        S_R1: if (mdone) begin
          rdur <= mres[31:0];
          rate[lead] <= accel[31] ? 32'sh7FFF_FFFF : $signed(accel);
          ma <= 64'(dot); mb <= 64'(accel); mdiv <= 1'b0;
          mstart <= 1'b1; st <= S_R2;
        end
        S_R2: if (mdone) begin
          ma <= mres[63:0]; mb <= 64'(dl); mdiv <= 1'b1;
          mstart <= 1'b1; st <= S_R3;
        end
        S_R3: if (mdone) begin
          rate[!lead] <= sat32(mres); st <= S_OUT;
        end
        S_P0: begin
          ma <= 64'($signed(cnt[w] - lastc[w])); mb <= 64'(w ? dpt_r : dpt_l);
          mdiv <= 1'b0; mstart <= 1'b1; lastc[w] <= cnt[w]; st <= S_P1;
        end
        S_P1: if (mdone) begin
          meas[w] <= sat32(mres);
          el = tm - rs_time;
          if (el < rdur) begin
            ma <= 64'(el); mb <= 64'(rate[w]); mstart <= 1'b1; st <= S_P2;
          end else begin
            ramped <= tgt[w]; st <= S_P3;
          end
        end
        S_P2: if (mdone) begin
          ramped <= sat32(mres); st <= S_P3;
        end
        S_P3: begin
          ma <= 64'(ramped); mb <= 64'(period); mstart <= 1'b1; st <= S_P4;
        end
        S_P4: if (mdone) begin
          e <= sat32(mres - 96'(meas[w]));
          ns = (97'(esum[w]) + 97'(sat32(mres - 96'(meas[w]))) > 97'(I48Max)) ? I48Max :
               (97'(esum[w]) + 97'(sat32(mres - 96'(meas[w]))) < 97'(I48Min)) ? I48Min :
               esum[w] + 48'(sat32(mres - 96'(meas[w])));
          esum[w] <= ns;
          hi <= 64'(ns >>> 24);
          lo <= 64'({1'b0, ns[23:0]});
          ma <= 64'(sat32(mres - 96'(meas[w]))); mb <= 64'(kp); mstart <= 1'b1;
          st <= S_P5;
        end
        S_P5: if (mdone) begin
          acc <= mres; ma <= 64'(e) - 64'(perr[w]); mb <= 64'(kd); mstart <= 1'b1;
          st <= S_P6;
        end
        S_P6: if (mdone) begin
          acc <= acc + mres; ma <= lo; mb <= 64'(ki); mstart <= 1'b1; st <= S_P7;
        end
        S_P7: if (mdone) begin
          acc <= (acc + mres) >>> 24; ma <= hi; mb <= 64'(ki); mstart <= 1'b1;
          st <= S_P8;
        end
        S_P8: if (mdone) begin
          drv[w] <= sat32(96'(drv[w]) + acc + mres);
          perr[w] <= e;
          st <= S_NEXT;
        end
        S_NEXT: if (w) st <= S_OUT; else begin
          w <= 1'b1; st <= S_P0;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1; m_tdata <= {drv[1], drv[0]}; m_tuser <= upd;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
      if (m_tvalid && m_tready && st != S_OUT) m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("double accept");
  a_out: assert property (@(posedge clk) disable iff (rst)
    st == S_OUT && (!m_tvalid || m_tready) |=> m_tvalid) else $error("result lost");
  a_upd: assert property (@(posedge clk) disable iff (rst)
    st == S_P0 |-> req) else $error("update on set beat");
`endif
endmodule
`default_nettype wire

@@ test/tb_dual_wheel_speed_pid_ramp_top.sv @@
// Self-checking testbench for the two-wheel ramped PID speed controller.
`timescale 1ns / 100ps
module tb_dual_wheel_speed_pid_ramp_top;
  import dwsp_pkg::*;

  localparam bit REQ_SET = 1'b0;
  localparam bit REQ_SAMPLE = 1'b1;
  localparam longint I32Hi = 64'sd2147483647;
  localparam longint I32Lo = -64'sd2147483648;
  localparam longint I48Hi = 64'sd140737488355327;
  localparam longint I48Lo = -64'sd140737488355328;
  localparam int CycleLimit = 8000000;
  localparam int RandItems = 1100;

  typedef struct {
    bit kind;
    bit [31:0] t, cl, cr, tl, tr;
    bit typed;
    bit [31:0] el, er;
    bit eu;
  } row_t;

  typedef struct {
    bit [31:0] pl, pr;
    bit upd;
  } pwm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic s_tuser = 1'b0;
  logic [159:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic m_tuser;
  logic [63:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  dual_wheel_speed_pid_ramp_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // controller mirror
  bit [15:0] period_q;
  bit [23:0] kp_q, kd_q, ki_q;
  bit [31:0] accel_q, dpt_q[2];
  bit [31:0] last_time, last_cnt[2], ramp_t0, ramp_len;
  longint speed_meas[2], err_acc[2], err_prev[2], drive[2], tgt[2], rate[2];

  pwm_t pwm_q[$];
  row_t dir_rows[$];
  int mism = 0, n_items = 0, n_upd = 0, n_beats_out = 0, n_cfg = 0;
  int hold_cycles = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  bit [31:0] cur_time = 0, cur_cnt[2];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void clear_mirror();
    period_q = 16'd10; kp_q = 24'd503316; kd_q = 24'd134218; ki_q = 24'd16777;
    accel_q = 32'd26214; dpt_q[0] = 32'd65536; dpt_q[1] = 32'd65536;
    last_time = 0; ramp_t0 = 0; ramp_len = 0;
    for (int w = 0; w < 2; w++) begin
      last_cnt[w] = 0; speed_meas[w] = 0; err_acc[w] = 0; err_prev[w] = 0;
      drive[w] = 0; tgt[w] = 0; rate[w] = 0;
    end
  endfunction

  function automatic void plan_ramp(bit [31:0] now);
    int ld, ot;
    longint dl, dot, acc_l;
    ld = (tgt[0] < tgt[1]) ? 1 : 0;
    ot = 1 - ld;
    acc_l = longint'({32'b0, accel_q});
    dl = clip(tgt[ld] - speed_meas[ld], I32Lo, I32Hi);
    dot = clip(tgt[ot] - speed_meas[ot], I32Lo, I32Hi);
    ramp_t0 = now;
    if (dl <= 0 || acc_l == 0) begin
      ramp_len = 0; rate[0] = 0; rate[1] = 0;
    end else begin
      ramp_len = 32'((dl + acc_l - 1) / acc_l);
      rate[ld] = clip(acc_l, 0, I32Hi);
      rate[ot] = clip(dot * acc_l / dl, I32Lo, I32Hi);
    end
  endfunction

  function automatic void wheel_update(int w, bit [31:0] now, bit [31:0] cnt);
    int tk;
    bit [31:0] el;
    longint ramped, e, de, hi, lo, acc;
    tk = int'(cnt - last_cnt[w]);
    last_cnt[w] = cnt;
    speed_meas[w] = clip(longint'(tk) * longint'({32'b0, dpt_q[w]}), I32Lo, I32Hi);
    el = now - ramp_t0;
    if (el < ramp_len) ramped = clip(longint'({32'b0, el}) * rate[w], I32Lo, I32Hi);
    else ramped = tgt[w];
    e = clip(ramped * longint'({48'b0, period_q}) - speed_meas[w], I32Lo, I32Hi);
    de = e - err_prev[w];
    err_acc[w] = clip(err_acc[w] + e, I48Lo, I48Hi);
    hi = err_acc[w] >>> 24;
    lo = err_acc[w] - (hi <<< 24);
    acc = longint'({40'b0, kp_q}) * e + longint'({40'b0, kd_q}) * de
        + longint'({40'b0, ki_q}) * lo;
    acc = longint'({40'b0, ki_q}) * hi + (acc >>> 24);
    drive[w] = clip(drive[w] + acc, I32Lo, I32Hi);
    err_prev[w] = e;
  endfunction

  function automatic pwm_t predict_pwm(row_t r);
    pwm_t p;
    p.upd = 1'b0;
    if (r.kind == REQ_SET) begin
      tgt[0] = longint'(int'(r.tl));
      tgt[1] = longint'(int'(r.tr));
      plan_ramp(r.t);
    end else if ((r.t - last_time) > {16'b0, period_q}) begin
      wheel_update(0, r.t, r.cl);
      wheel_update(1, r.t, r.cr);
      last_time = r.t;
      p.upd = 1'b1;
    end
    p.pl = drive[0][31:0];
    p.pr = drive[1][31:0];
    return p;
  endfunction

  function automatic row_t mk(bit k, bit [31:0] t, bit [31:0] cl, bit [31:0] cr,
                              bit [31:0] tl, bit [31:0] tr);
    row_t r;
    r.kind = k; r.t = t; r.cl = cl; r.cr = cr; r.tl = tl; r.tr = tr;
    r.typed = 1'b0; r.el = 0; r.er = 0; r.eu = 0;
    return r;
  endfunction

  function automatic row_t mk_idle(bit k, bit [31:0] t, bit [31:0] tl, bit [31:0] tr);
    row_t r;
    r = mk(k, t, 0, 0, tl, tr);
    r.typed = 1'b1;
    return r;
  endfunction

  task automatic push_beat(row_t r);
    pwm_t p;
    s_tuser <= r.kind;
    s_tdata <= {r.tr, r.tl, r.cr, r.cl, r.t};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    p = predict_pwm(r);
    if (r.typed) begin
      p.pl = r.el; p.pr = r.er; p.upd = r.eu;
    end
    pwm_q.push_back(p);
    n_items++;
    if (burst_left > 0) burst_left--;
    else if (gaps_on) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pwm_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(bit [31:0] per, bit [31:0] kp, bit [31:0] kd, bit [31:0] ki,
                           bit [31:0] acc, bit [31:0] dl, bit [31:0] dr);
    bit [31:0] v[7];
    v = '{per, kp, kd, ki, acc, dl, dr};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= v[i];
      @(posedge clk);
      case (CfgIdxW'(i))
        REG_PERIOD: period_q = v[i][15:0];
        REG_KP: kp_q = v[i][23:0];
        REG_KD: kd_q = v[i][23:0];
        REG_KI: ki_q = v[i][23:0];
        REG_ACCEL: accel_q = v[i];
        REG_DPT_L: dpt_q[0] = v[i];
        REG_DPT_R: dpt_q[1] = v[i];
        default: ;
      endcase
      n_cfg++;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [31:0] near(int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r = mk(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, $urandom);
      cur_time = r.t; cur_cnt[0] = r.cl; cur_cnt[1] = r.cr;
    end else if (pick < 25) begin
      cur_time += $urandom_range(0, 5);
      if (pick < 18) r = mk(REQ_SET, cur_time, 0, 0, near(400000), near(400000));
      else r = mk(REQ_SET, cur_time, $urandom, $urandom, $urandom, $urandom);
    end else begin
      if (pick < 33) cur_time += $urandom_range(0, period_q);
      else cur_time += period_q + $urandom_range(1, 40);
      cur_cnt[0] += near(300);
      cur_cnt[1] += near(300);
      r = mk(REQ_SAMPLE, cur_time, cur_cnt[0], cur_cnt[1], $urandom, $urandom);
    end
    return r;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) push_beat(rand_row());
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    pwm_t x;
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (cycles[9]) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      n_beats_out++;
      if (pwm_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected beat: pwm %h upd %b", m_tdata, m_tuser);
      end else begin
        x = pwm_q.pop_front();
        if (m_tdata[31:0] !== x.pl || m_tdata[63:32] !== x.pr || m_tuser !== x.upd) begin
          mism++;
          if (mism <= 10)
            $display("mismatch: exp L %h R %h upd %b, got L %h R %h upd %b",
                     x.pl, x.pr, x.upd, m_tdata[31:0], m_tdata[63:32], m_tuser);
        end
        if (x.upd) n_upd++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** dual_wheel_speed_pid_ramp_top: FAILED **");
      $finish;
    end
  end

  initial begin
    clear_mirror();
    cur_cnt[0] = 0; cur_cnt[1] = 0;
    dir_rows.push_back(mk_idle(REQ_SAMPLE, 32'd5, 0, 0));
    dir_rows.push_back(mk_idle(REQ_SAMPLE, 32'd10, 0, 0));
    dir_rows.push_back(mk_idle(REQ_SET, 32'd10, 32'h0001_0000, 32'h0002_0000));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd21, 32'd1, 32'd2, 0, 0));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd32, 32'd3, 32'd5, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 32'd33, 0, 0, 32'h0003_0000, 32'h0001_0000));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd50, 32'd6, 32'd7, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 32'd51, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd70, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd90, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 32'd91, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd120, 32'h8000_0000, 32'h8000_0000, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 32'd121, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd140, 32'd0, 32'd0, 0, 0));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd1, 0, 0));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd5, 32'd2, 32'hFFFF_FFFE, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 32'd6, 0, 0, 32'd0, 32'd0));
    dir_rows.push_back(mk(REQ_SAMPLE, 32'd40, 32'd2, 32'hFFFF_FFFE, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) push_beat(dir_rows[i]);
    drain();
    cur_time = 32'd40; cur_cnt[0] = 32'd2; cur_cnt[1] = 32'hFFFF_FFFE;

    run_random(RandItems / 8);
    drain();

    write_cfg(32'd1, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF);
    gaps_on = 1'b0;
    run_random(RandItems / 8);
    drain();

    write_cfg(32'd65535, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    gaps_on = 1'b1;
    run_random(RandItems / 16);
    drain();

    write_cfg(32'd20, 32'd800000, 32'd200000, 32'd30000, 32'd60000, 32'd70000, 32'd50000);
    hold_cycles = 4000;
    run_random(RandItems / 8);
    // hold off until every result is back, then carry on
    s_tvalid <= 1'b0;
    while (pwm_q.size() != 0) @(posedge clk);
    run_random(RandItems / 8);
    drain();

    write_cfg($urandom_range(1, 50), $urandom_range(0, 24'hFF_FFFF),
              $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
              $urandom_range(1, 32'hFFFF_FFFF), $urandom, $urandom);
    run_random(RandItems / 8);
    drain();

    write_cfg(32'd10, 32'd503316, 32'd134218, 32'd16777, 32'd26214, 32'd65536, 32'd65536);
    run_random(RandItems / 4);
    drain();

    $display("covered %0d beats in, %0d control updates, %0d register writes",
             n_items, n_upd, n_cfg);
    $display("%0d beats out, %0d mismatches, %0d cycles", n_beats_out, mism, cycles);
    if (mism == 0 && pwm_q.size() == 0) begin
      $display("** dual_wheel_speed_pid_ramp_top: PASSED **");
    end else begin
      $display("** dual_wheel_speed_pid_ramp_top: FAILED **");
    end
    $finish;
  end
endmodule
